FILE: rtl/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define CHK_SAME(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define CHK_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

// Next-cycle implication that also watches reset itself.
`define CHK_NEXT_ANY(lbl, clk, pre, post, msg) \
   lbl: assert property (@(posedge clk) (pre) |=> (post)) \
      else $error(msg);

`endif

FILE: rtl/bmprt_pkg.sv
// Shared types, codes and helpers of the BMP row to tricolor pixel decoder.
package bmprt_pkg;

   localparam int MAX_DIM = 1024;
   localparam int COORD_W = $clog2(MAX_DIM);

   localparam int CMD_DEPTH   = 4;
   localparam int OUT_DEPTH   = 4;
   localparam int OUT_COUNT_W = $clog2(OUT_DEPTH + 1);

   localparam logic [7:0] WHITE_LIMIT = 8'h80;
   localparam logic [7:0] COLOR_LIMIT = 8'hF0;
   localparam logic [9:0] SUM_LIMIT   = 10'(3 * 128);

   typedef enum logic [2:0] {
      REG_DEPTH_CODE  = 3'd0,
      REG_FORMAT_565  = 3'd1,
      REG_WITH_COLOR  = 3'd2,
      REG_IMAGE_WIDTH = 3'd3,
      REG_DRAW_WIDTH  = 3'd4,
      REG_DRAW_HEIGHT = 3'd5,
      REG_ORIGIN_X    = 3'd6,
      REG_ORIGIN_Y    = 3'd7
   } reg_index_type;

   typedef enum logic [2:0] {
      DEPTH_1BPP  = 3'd0,
      DEPTH_4BPP  = 3'd1,
      DEPTH_8BPP  = 3'd2,
      DEPTH_16BPP = 3'd3,
      DEPTH_24BPP = 3'd4
   } depth_type;

   typedef enum logic [1:0] {
      COLOR_WHITE = 2'd0,
      COLOR_BLACK = 2'd1,
      COLOR_RED   = 2'd2
   } color_type;

   typedef enum logic [1:0] {
      OP_PALETTE = 2'd0,
      OP_UNPACK  = 2'd1,
      OP_DIRECT  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      UNPACK_1 = 2'd0,
      UNPACK_4 = 2'd1,
      UNPACK_8 = 2'd2
   } unpack_type;

   // One unit of work handed from the front end to the back end.
   typedef struct packed {
      op_type               op;
      unpack_type           unpack;
      logic [7:0]           data;      // data byte, or palette index
      logic [2:0]           last_pix;  // drawn pixels in this byte minus one
      logic [COORD_W-1:0]   x;         // column of the first pixel
      logic [COORD_W-1:0]   y;
      logic                 white_mark;
      logic                 red_mark;
      logic                 color_en;
      color_type            color;     // resolved color of a direct pixel
   } cmd_type;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      color_type          color;
      logic               last;
   } pix_type;

   function automatic color_type pick_color(input logic white, input logic red,
                                            input logic color_en);
      color_type c;
      if (white) begin
         c = COLOR_WHITE;
      end else if (red && color_en) begin
         c = COLOR_RED;
      end else begin
         c = COLOR_BLACK;
      end
      return c;
   endfunction

endpackage

FILE: rtl/bmp_row_to_tricolor_pixels.sv
// Top level of the BMP row to tricolor pixel decoder.
//
//   channel   direction  handshake          beat carries
//   req_      in         req_push/req_full  kind, data byte, palette index and RGB
//   rsp_      out        rsp_empty/rsp_pop  pixel x, y, color, last-of-byte flag
//   csr_      in         csr_write          register index and 10-bit value
//
// The front end takes one req beat per cycle while its command queue has room;
//   the back end emits one pixel per cycle while the result queue has room and
//   expands a 1 bpp byte into up to eight pixels, a 4 bpp byte into up to two
//   and any other drawn pixel into one; a palette entry yields no pixel, and
//   bytes that draw nothing never reach it.
// A data byte's first pixel passes the command queue, the palette read and the
//   result queue, each registered, before it shows on rsp_ and can be popped.
// Reset is synchronous and active high; the palette store has no clearing pass
//   and holds garbage until written.
// A stalled rsp_pop fills the result queue, then the command queue, then
//   raises req_full; configuration writes are taken in any cycle.
module bmp_row_to_tricolor_pixels #(
   parameter int PALETTE_SIZE = 256
) (
   input  logic       clock,
   input  logic       reset,
   // configuration
   input  logic       csr_write,
   input  logic [2:0] csr_index,
   input  logic [9:0] csr_data,
   // input items
   input  logic       req_push,
   output logic       req_full,
   input  logic       req_kind,
   input  logic [7:0] req_data_byte,
   input  logic [7:0] req_entry_index,
   input  logic [7:0] req_entry_red,
   input  logic [7:0] req_entry_green,
   input  logic [7:0] req_entry_blue,
   // result pixels
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [9:0] rsp_pixel_x,
   output logic [9:0] rsp_pixel_y,
   output logic [1:0] rsp_pixel_color,
   output logic       rsp_last_of_item
);

   localparam int CMD_W = $bits(bmprt_pkg::cmd_type);
   localparam int PIX_W = $bits(bmprt_pkg::pix_type);

   // front end to command queue
   logic                                  front_push;
   bmprt_pkg::cmd_type                    front_cmd;
   logic                                  cmd_full;

   // command queue to back end
   bmprt_pkg::cmd_type                    head_cmd;
   logic                                  cmd_empty;
   logic                                  cmd_pop;
   logic [$clog2(bmprt_pkg::CMD_DEPTH+1)-1:0] cmd_count;

   // back end to result queue
   logic                                  pix_push;
   bmprt_pkg::pix_type                    pix_in;
   bmprt_pkg::pix_type                    pix_out;
   logic [bmprt_pkg::OUT_COUNT_W-1:0]     out_count;
   logic                                  out_full;

   // hold off the source only when the command queue is full
   assign req_full = cmd_full;

   bmprt_front u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_push        (req_push),
      .req_full        (cmd_full),
      .req_kind        (req_kind),
      .req_data_byte   (req_data_byte),
      .req_entry_index (req_entry_index),
      .req_entry_red   (req_entry_red),
      .req_entry_green (req_entry_green),
      .req_entry_blue  (req_entry_blue),
      .cmd_push        (front_push),
      .cmd             (front_cmd)
   );

   bmprt_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (bmprt_pkg::CMD_DEPTH)
   ) u_cmd_queue (
      .clock (clock),
      .reset (reset),
      .push  (front_push),
      .wdata (front_cmd),
      .pop   (cmd_pop),
      .rdata (head_cmd),
      .count (cmd_count),
      .full  (cmd_full),
      .empty (cmd_empty)
   );

   bmprt_back #(
      .PALETTE_SIZE (PALETTE_SIZE)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (head_cmd),
      .cmd_empty (cmd_empty || (cmd_count == '0)),
      .cmd_pop   (cmd_pop),
      .out_count (out_count),
      .out_push  (pix_push),
      .pix       (pix_in)
   );

   // the back end reserves room by credit, so out_full never blocks a push
   bmprt_fifo #(
      .WIDTH (PIX_W),
      .DEPTH (bmprt_pkg::OUT_DEPTH)
   ) u_out_queue (
      .clock (clock),
      .reset (reset),
      .push  (pix_push && !out_full),
      .wdata (pix_in),
      .pop   (rsp_pop),
      .rdata (pix_out),
      .count (out_count),
      .full  (out_full),
      .empty (rsp_empty)
   );

   assign rsp_pixel_x      = pix_out.x;
   assign rsp_pixel_y      = pix_out.y;
   assign rsp_pixel_color  = pix_out.color;
   assign rsp_last_of_item = pix_out.last;

endmodule

FILE: rtl/bmprt_fifo.sv
// Small register-based first-in first-out queue.
module bmprt_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           wdata,
   input  logic                       pop,
   output logic [WIDTH-1:0]           rdata,
   output logic [$clog2(DEPTH+1)-1:0] count,
   output logic                       full,
   output logic                       empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign count   = count_ff;
   assign rdata   = store_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      if (do_push && !do_pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

FILE: rtl/bmprt_front.sv
// Front end: configuration registers, row and byte tracking, command building.
module bmprt_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write,
   input  logic [2:0]          csr_index,
   input  logic [9:0]          csr_data,
   input  logic                req_push,
   input  logic                req_full,
   input  logic                req_kind,
   input  logic [7:0]          req_data_byte,
   input  logic [7:0]          req_entry_index,
   input  logic [7:0]          req_entry_red,
   input  logic [7:0]          req_entry_green,
   input  logic [7:0]          req_entry_blue,
   output logic                cmd_push,
   output bmprt_pkg::cmd_type  cmd
);

   localparam int CW = bmprt_pkg::COORD_W;

   // configuration
   logic [2:0]    depth_code_ff;
   logic          format_565_ff;
   logic          with_color_ff;
   logic [9:0]    image_width_ff;
   logic [9:0]    draw_width_ff;
   logic [9:0]    draw_height_ff;
   logic [9:0]    origin_x_ff;
   logic [9:0]    origin_y_ff;

   // stream state
   logic [15:0]   held_ff, held_in;
   logic [1:0]    phase_ff, phase_in;
   logic [11:0]   row_bytes_ff, row_bytes_in;
   logic [9:0]    column_ff, column_in;
   logic [9:0]    row_ff, row_in;

   logic          accept;
   logic          color_en;
   logic [9:0]    eff_w;
   logic [11:0]   stored_bytes;
   logic [12:0]   rounded_bytes;
   logic [11:0]   row_size;
   logic          row_done;
   logic [9:0]    row_next;
   logic [CW-1:0] pix_x;
   logic [CW-1:0] pix_y;
   logic [9:0]    avail;
   logic [3:0]    per_byte;
   logic [3:0]    n_pix;
   logic          column_open;
   logic [7:0]    r16, g16, b16;
   logic [1:0]    marks_palette, marks_16, marks_24;

   function automatic logic [1:0] classify(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b, input logic en);
      logic [9:0] sum;
      logic       wh;
      logic       co;
      sum = 10'(r) + 10'(g) + 10'(b);
      if (en) begin
         wh = (r > bmprt_pkg::WHITE_LIMIT) && (g > bmprt_pkg::WHITE_LIMIT)
              && (b > bmprt_pkg::WHITE_LIMIT);
      end else begin
         wh = sum > bmprt_pkg::SUM_LIMIT;
      end
      co = (r > bmprt_pkg::COLOR_LIMIT)
           || ((g > bmprt_pkg::COLOR_LIMIT) && (b > bmprt_pkg::COLOR_LIMIT));
      return {wh, co};
   endfunction

   assign accept   = req_push && !req_full;
   assign color_en = with_color_ff && (depth_code_ff != bmprt_pkg::DEPTH_1BPP);
   assign eff_w    = (draw_width_ff < image_width_ff) ? draw_width_ff : image_width_ff;

   // bytes per stored row, before the rounding to a multiple of four below
   always_comb begin
      case (depth_code_ff)
         bmprt_pkg::DEPTH_1BPP:  stored_bytes = ({2'b00, image_width_ff} + 12'd7) >> 3;
         bmprt_pkg::DEPTH_4BPP:  stored_bytes = ({2'b00, image_width_ff} + 12'd1) >> 1;
         bmprt_pkg::DEPTH_8BPP:  stored_bytes = {2'b00, image_width_ff};
         bmprt_pkg::DEPTH_16BPP: stored_bytes = {1'b0, image_width_ff, 1'b0};
         default:                stored_bytes = {2'b00, image_width_ff}
                                                + {1'b0, image_width_ff, 1'b0};
      endcase
   end

   assign rounded_bytes = {1'b0, stored_bytes} + 13'd3;
   assign row_size      = {rounded_bytes[11:2], 2'b00};
   assign row_done      = ({1'b0, row_bytes_ff} + 13'd1) >= {1'b0, row_size};
   assign row_next      = (row_ff + 10'd1 == 10'd0) ? 10'h3FF : 10'(row_ff + 10'd1);

   assign pix_x = CW'(origin_x_ff + column_ff);
   assign pix_y = CW'(origin_y_ff + draw_height_ff - row_ff - 10'd1);

   assign column_open = column_ff < eff_w;
   assign avail       = column_open ? 10'(eff_w - column_ff) : 10'd0;

   // 16-bit pixel from the held low byte and the incoming high byte
   always_comb begin
      b16 = {held_ff[4:0], 3'b000};
      if (format_565_ff) begin
         g16 = {req_data_byte[2:0], held_ff[7:5], 2'b00};
         r16 = {req_data_byte[7:3], 3'b000};
      end else begin
         g16 = {req_data_byte[1:0], held_ff[7:5], 3'b000};
         r16 = {req_data_byte[6:2], 3'b000};
      end
   end

   assign marks_palette = classify(req_entry_red, req_entry_green, req_entry_blue, color_en);
   assign marks_16      = classify(r16, g16, b16, color_en);
   assign marks_24      = classify(req_data_byte, held_ff[15:8], held_ff[7:0], color_en);

   always_comb begin
      case (depth_code_ff)
         bmprt_pkg::DEPTH_1BPP: per_byte = 4'd8;
         bmprt_pkg::DEPTH_4BPP: per_byte = 4'd2;
         default:               per_byte = 4'd1;
      endcase
      n_pix = (avail < {6'b0, per_byte}) ? avail[3:0] : per_byte;
   end

   always_comb begin
      held_in      = held_ff;
      phase_in     = phase_ff;
      row_bytes_in = row_bytes_ff;
      column_in    = column_ff;
      row_in       = row_ff;
      cmd_push     = 1'b0;
      cmd          = '0;
      cmd.x        = pix_x;
      cmd.y        = pix_y;
      cmd.data     = req_data_byte;
      cmd.color_en = color_en;
      cmd.op       = bmprt_pkg::OP_DIRECT;
      cmd.unpack   = bmprt_pkg::UNPACK_8;
      cmd.color    = bmprt_pkg::COLOR_BLACK;
      if (accept) begin
         if (!req_kind) begin
            cmd_push       = 1'b1;
            cmd.op         = bmprt_pkg::OP_PALETTE;
            cmd.data       = req_entry_index;
            cmd.white_mark = marks_palette[1];
            cmd.red_mark   = marks_palette[0];
         end else if (row_ff < draw_height_ff) begin
            case (depth_code_ff) inside
               bmprt_pkg::DEPTH_1BPP, bmprt_pkg::DEPTH_4BPP, bmprt_pkg::DEPTH_8BPP: begin
                  cmd.op       = bmprt_pkg::OP_UNPACK;
                  cmd.last_pix = 3'(n_pix - 4'd1);
                  case (depth_code_ff)
                     bmprt_pkg::DEPTH_1BPP: cmd.unpack = bmprt_pkg::UNPACK_1;
                     bmprt_pkg::DEPTH_4BPP: cmd.unpack = bmprt_pkg::UNPACK_4;
                     default:               cmd.unpack = bmprt_pkg::UNPACK_8;
                  endcase
                  cmd_push  = (n_pix != 4'd0);
                  column_in = column_ff + 10'(n_pix);
               end
               bmprt_pkg::DEPTH_16BPP: begin
                  if (phase_ff == 2'd0) begin
                     held_in  = {8'h00, req_data_byte};
                     phase_in = 2'd1;
                  end else begin
                     held_in  = '0;
                     phase_in = 2'd0;
                     if (column_open) begin
                        cmd_push  = 1'b1;
                        cmd.color = bmprt_pkg::pick_color(marks_16[1], marks_16[0], color_en);
                        column_in = 10'(column_ff + 10'd1);
                     end
                  end
               end
               default: begin
                  if (phase_ff == 2'd0) begin
                     held_in  = {8'h00, req_data_byte};
                     phase_in = 2'd1;
                  end else if (phase_ff == 2'd1) begin
                     held_in  = {req_data_byte, held_ff[7:0]};
                     phase_in = 2'd2;
                  end else begin
                     held_in  = '0;
                     phase_in = 2'd0;
                     if (column_open) begin
                        cmd_push  = 1'b1;
                        cmd.color = bmprt_pkg::pick_color(marks_24[1], marks_24[0], color_en);
                        column_in = 10'(column_ff + 10'd1);
                     end
                  end
               end
            endcase
            // padding and clipped bytes still count toward the row
            if (row_done) begin
               row_bytes_in = '0;
               column_in    = '0;
               phase_in     = '0;
               held_in      = '0;
               row_in       = row_next;
            end else begin
               row_bytes_in = 12'(row_bytes_ff + 12'd1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_code_ff  <= bmprt_pkg::DEPTH_24BPP;
         format_565_ff  <= 1'b0;
         with_color_ff  <= 1'b0;
         image_width_ff <= 10'd1;
         draw_width_ff  <= '0;
         draw_height_ff <= '0;
         origin_x_ff    <= '0;
         origin_y_ff    <= '0;
         held_ff        <= '0;
         phase_ff       <= '0;
         row_bytes_ff   <= '0;
         column_ff      <= '0;
         row_ff         <= '0;
      end else begin
         held_ff      <= held_in;
         phase_ff     <= phase_in;
         row_bytes_ff <= row_bytes_in;
         column_ff    <= column_in;
         row_ff       <= row_in;
         if (csr_write) begin
            unique case (csr_index)
               bmprt_pkg::REG_DEPTH_CODE:  depth_code_ff  <= csr_data[2:0];
               bmprt_pkg::REG_FORMAT_565:  format_565_ff  <= csr_data[0];
               bmprt_pkg::REG_WITH_COLOR:  with_color_ff  <= csr_data[0];
               bmprt_pkg::REG_IMAGE_WIDTH: image_width_ff <= csr_data;
               bmprt_pkg::REG_DRAW_WIDTH:  draw_width_ff  <= csr_data;
               bmprt_pkg::REG_DRAW_HEIGHT: draw_height_ff <= csr_data;
               bmprt_pkg::REG_ORIGIN_X:    origin_x_ff    <= csr_data;
               bmprt_pkg::REG_ORIGIN_Y:    origin_y_ff    <= csr_data;
            endcase
         end
      end
   end

endmodule

FILE: rtl/bmprt_back.sv
// Back end: palette store; expands commands one pixel per cycle on credit.
module bmprt_back #(
   parameter int PALETTE_SIZE = 256
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  bmprt_pkg::cmd_type                    cmd,
   input  logic                                  cmd_empty,
   output logic                                  cmd_pop,
   input  logic [bmprt_pkg::OUT_COUNT_W-1:0]     out_count,
   output logic                                  out_push,
   output bmprt_pkg::pix_type                    pix
);

   localparam int AW = $clog2(PALETTE_SIZE);
   localparam int CW = bmprt_pkg::COORD_W;
   localparam int SUM_W = bmprt_pkg::OUT_COUNT_W + 1;

   logic [1:0]      mark_mem [PALETTE_SIZE];
   logic [1:0]      rd_marks_ff;

   logic [2:0]      pix_k_ff;
   logic            s1_valid_ff;
   logic [CW-1:0]   s1_x_ff;
   logic [CW-1:0]   s1_y_ff;
   logic            s1_last_ff;
   logic            s1_direct_ff;
   logic            s1_color_en_ff;
   bmprt_pkg::color_type s1_color_ff;

   logic            credit;
   logic            issue;
   logic            wr_en;
   logic            last_k;
   logic [7:0]      pix_num;

   // leave room for the pixel still waiting on its palette read
   assign credit = (SUM_W'(out_count) + SUM_W'(s1_valid_ff)) < SUM_W'(bmprt_pkg::OUT_DEPTH);
   assign last_k = (pix_k_ff == cmd.last_pix);

   always_comb begin
      issue   = 1'b0;
      wr_en   = 1'b0;
      cmd_pop = 1'b0;
      unique case (cmd.op)
         bmprt_pkg::OP_PALETTE: begin
            wr_en   = !cmd_empty && ({1'b0, cmd.data} < 9'(PALETTE_SIZE));
            cmd_pop = !cmd_empty;
         end
         bmprt_pkg::OP_UNPACK: begin
            issue   = !cmd_empty && credit;
            cmd_pop = issue && last_k;
         end
         bmprt_pkg::OP_DIRECT: begin
            issue   = !cmd_empty && credit;
            cmd_pop = issue;
         end
         default: begin
            cmd_pop = !cmd_empty;
         end
      endcase
   end

   // palette index of the current pixel, most significant bits first
   always_comb begin
      case (cmd.unpack)
         bmprt_pkg::UNPACK_1: pix_num = {7'b0, cmd.data[3'(3'd7 - pix_k_ff)]};
         bmprt_pkg::UNPACK_4: pix_num = pix_k_ff[0] ? {4'b0, cmd.data[3:0]}
                                                    : {4'b0, cmd.data[7:4]};
         default:             pix_num = cmd.data;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mark_mem[cmd.data[AW-1:0]] <= {cmd.white_mark, cmd.red_mark};
      end
      rd_marks_ff <= mark_mem[pix_num[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_k_ff    <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= issue;
         if (issue && (cmd.op == bmprt_pkg::OP_UNPACK)) begin
            pix_k_ff <= last_k ? 3'd0 : 3'(pix_k_ff + 3'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_x_ff        <= CW'(cmd.x + CW'(pix_k_ff));
         s1_y_ff        <= cmd.y;
         s1_last_ff     <= (cmd.op == bmprt_pkg::OP_DIRECT) || last_k;
         s1_direct_ff   <= (cmd.op == bmprt_pkg::OP_DIRECT);
         s1_color_en_ff <= cmd.color_en;
         s1_color_ff    <= cmd.color;
      end
   end

   assign out_push  = s1_valid_ff;
   assign pix.x     = s1_x_ff;
   assign pix.y     = s1_y_ff;
   assign pix.last  = s1_last_ff;
   assign pix.color = s1_direct_ff ? s1_color_ff
                    : bmprt_pkg::pick_color(rd_marks_ff[1], rd_marks_ff[0], s1_color_en_ff);

endmodule

FILE: rtl/bmprt_checker.sv
// Port-level checks of the decoder, attached to the top level by bind.
`include "assert_macros.svh"

module bmprt_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_full,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic [9:0] rsp_pixel_x,
   input logic [9:0] rsp_pixel_y,
   input logic [1:0] rsp_pixel_color,
   input logic       rsp_last_of_item
);

   logic       pop_fire;
   logic       prev_valid_ff, prev_valid_in;
   logic       prev_last_ff, prev_last_in;
   logic [9:0] prev_x_ff, prev_x_in;
   logic [9:0] prev_y_ff, prev_y_in;

   assign pop_fire = rsp_pop && !rsp_empty;

   always_comb begin
      prev_valid_in = prev_valid_ff;
      prev_last_in  = prev_last_ff;
      prev_x_in     = prev_x_ff;
      prev_y_in     = prev_y_ff;
      if (pop_fire) begin
         prev_valid_in = 1'b1;
         prev_last_in  = rsp_last_of_item;
         prev_x_in     = rsp_pixel_x;
         prev_y_in     = rsp_pixel_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_valid_ff <= 1'b0;
         prev_last_ff  <= 1'b1;
         prev_x_ff     <= '0;
         prev_y_ff     <= '0;
      end else begin
         prev_valid_ff <= prev_valid_in;
         prev_last_ff  <= prev_last_in;
         prev_x_ff     <= prev_x_in;
         prev_y_ff     <= prev_y_in;
      end
   end

   `CHK_NEXT_ANY(a_reset_clears, clock, reset, rsp_empty && !req_full,
      "queues not empty after reset")

   `CHK_NEXT(a_result_holds, clock, reset, !rsp_empty && !rsp_pop,
      !rsp_empty && $stable(rsp_pixel_x) && $stable(rsp_pixel_y)
      && $stable(rsp_pixel_color) && $stable(rsp_last_of_item),
      "waiting result changed without a pop")

   `CHK_SAME(a_color_code, clock, reset, !rsp_empty, rsp_pixel_color != 2'd3,
      "undefined pixel color code")

   `CHK_SAME(a_byte_run, clock, reset, pop_fire && prev_valid_ff && !prev_last_ff,
      rsp_pixel_x == 10'(prev_x_ff + 10'd1) && rsp_pixel_y == prev_y_ff,
      "pixels of one byte not on consecutive columns")

endmodule

bind bmp_row_to_tricolor_pixels bmprt_checker u_bmprt_checker (.*);

FILE: sim/bmp_row_to_tricolor_pixels_test.sv
// Testbench for the BMP row to tricolor pixel decoder: directed and random beats.
`timescale 1ns / 100ps

module bmp_row_to_tricolor_pixels_test;

   // Beat kinds on the req_ channel.
   localparam logic KIND_ENTRY = 1'b0;
   localparam logic KIND_DATA  = 1'b1;

   // Depth codes above 24 bpp decode as 24 bpp.
   localparam logic [2:0] DEPTH_BEYOND_MAX = 3'd7;

   localparam int RANDOM_BEATS   = 190;
   localparam int WATCHDOG_LIMIT = 2000;
   // Pixel pipe is 3 deep; allow room for palette beats still in the command queue.
   localparam int SETTLE_CYCLES  = 12;

   typedef struct packed {
      logic [9:0]           x;
      logic [9:0]           y;
      bmprt_pkg::color_type color;
      logic                 last;
   } drawn_pixel_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_write = 1'b0;
   logic [2:0] csr_index = '0;
   logic [9:0] csr_data = '0;
   logic       req_push = 1'b0;
   logic       req_full;
   logic       req_kind = 1'b0;
   logic [7:0] req_data_byte = '0;
   logic [7:0] req_entry_index = '0;
   logic [7:0] req_entry_red = '0;
   logic [7:0] req_entry_green = '0;
   logic [7:0] req_entry_blue = '0;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   logic [9:0] rsp_pixel_x;
   logic [9:0] rsp_pixel_y;
   logic [1:0] rsp_pixel_color;
   logic       rsp_last_of_item;

   // Pixels predicted but not yet popped, oldest first.
   drawn_pixel_type pixels_due[$];
   int              mismatch_count = 0;
   int              quiet_cycles = 0;
   bit              steady = 1'b0;  // when set, neither side idles

   // Shadow of the register file.
   logic [2:0] mode_depth = bmprt_pkg::DEPTH_24BPP;
   logic       mode_565 = 1'b0;
   logic       mode_color = 1'b0;
   int         mode_image_w = 1;
   int         mode_draw_w = 0;
   int         mode_height = 0;
   int         mode_ox = 0;
   int         mode_oy = 0;

   // Shadow of the decoder state: palette marks are {whitish, colored}.
   logic [1:0] palette_marks [256];
   bit         entry_written [256];
   int         held = 0;
   int         phase = 0;
   int         row_pos = 0;
   int         column = 0;
   int         row_num = 0;

   bmp_row_to_tricolor_pixels dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_kind        (req_kind),
      .req_data_byte   (req_data_byte),
      .req_entry_index (req_entry_index),
      .req_entry_red   (req_entry_red),
      .req_entry_green (req_entry_green),
      .req_entry_blue  (req_entry_blue),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_last_of_item(rsp_last_of_item)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // Pixel predictor
   // ------------------------------------------------------------------

   function automatic int pixel_bits();
      case (mode_depth)
         bmprt_pkg::DEPTH_1BPP:  return 1;
         bmprt_pkg::DEPTH_4BPP:  return 4;
         bmprt_pkg::DEPTH_8BPP:  return 8;
         bmprt_pkg::DEPTH_16BPP: return 16;
         default:                return 24;
      endcase
   endfunction

   // Red output needs the enable and is always off at 1 bpp.
   function automatic bit color_on();
      return mode_color && mode_depth != bmprt_pkg::DEPTH_1BPP;
   endfunction

   function automatic int padded_row_size();
      return ((mode_image_w * pixel_bits() + 7) / 8 + 3) & ~3;
   endfunction

   // Classify one RGB triple into {whitish, colored}.
   function automatic logic [1:0] grade_rgb(int r, int g, int b);
      logic whitish, colored;
      if (color_on()) begin
         whitish = r > 'h80 && g > 'h80 && b > 'h80;
      end else begin
         whitish = r + g + b > 3 * 'h80;
      end
      colored = r > 'hF0 || (g > 'hF0 && b > 'hF0);
      return {whitish, colored};
   endfunction

   function automatic bmprt_pkg::color_type shade(logic [1:0] marks);
      if (marks[1]) return bmprt_pkg::COLOR_WHITE;
      if (marks[0] && color_on()) return bmprt_pkg::COLOR_RED;
      return bmprt_pkg::COLOR_BLACK;
   endfunction

   // Place a pixel at the current column and row; rows count up from the bottom.
   function automatic drawn_pixel_type place(bmprt_pkg::color_type c);
      drawn_pixel_type p;
      p.x     = 10'((mode_ox + column) % bmprt_pkg::MAX_DIM);
      p.y     = 10'((mode_oy + mode_height + 4 * bmprt_pkg::MAX_DIM - 1 - row_num)
                    % bmprt_pkg::MAX_DIM);
      p.color = c;
      p.last  = 1'b0;
      return p;
   endfunction

   // Advance the shadow state by one accepted beat and queue the pixels it draws.
   task automatic decode_beat(input logic kind, input logic [7:0] data, input logic [7:0] index,
                              input logic [7:0] red, input logic [7:0] green,
                              input logic [7:0] blue);
      drawn_pixel_type batch[$];
      int bpp, span, row_len, slot, pen, r, g, b, lsb, msb;
      if (kind == KIND_ENTRY) begin
         palette_marks[index] = grade_rgb(red, green, blue);
         entry_written[index] = 1'b1;
         return;
      end
      // Drop data once every drawn row is done.
      if (row_num >= mode_height) return;
      bpp     = pixel_bits();
      span    = (mode_draw_w < mode_image_w) ? mode_draw_w : mode_image_w;
      row_len = padded_row_size();
      if (bpp < 16) begin
         // Palette pixels, leftmost in the high bits.
         for (slot = 0; slot < 8 / bpp; slot++) begin
            pen = (int'(data) >> (8 - (slot + 1) * bpp)) & ((1 << bpp) - 1);
            if (column < span) begin
               batch.push_back(place(shade(palette_marks[pen])));
               column++;
            end
         end
      end else if (phase == 0) begin
         held  = data;
         phase = 1;
      end else if (bpp == 16) begin
         lsb = held & 'hFF;
         msb = data;
         b   = (lsb & 'h1F) << 3;
         if (mode_565) begin
            g = ((msb & 'h07) << 5) | ((lsb & 'hE0) >> 3);
            r = msb & 'hF8;
         end else begin
            g = ((msb & 'h03) << 6) | ((lsb & 'hE0) >> 2);
            r = (msb & 'h7C) << 1;
         end
         phase = 0;
         held  = 0;
         if (column < span) begin
            batch.push_back(place(shade(grade_rgb(r, g, b))));
            column++;
         end
      end else if (phase == 1) begin
         held  = (held & 'hFF) | (int'(data) << 8);
         phase = 2;
      end else begin
         // Stored order is blue, green, red.
         b     = held & 'hFF;
         g     = (held >> 8) & 'hFF;
         phase = 0;
         held  = 0;
         if (column < span) begin
            batch.push_back(place(shade(grade_rgb(data, g, b))));
            column++;
         end
      end
      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
      foreach (batch[k]) pixels_due.push_back(batch[k]);
      // Close the row once its padded size is consumed.
      if (row_pos + 1 >= row_len) begin
         row_pos = 0;
         column  = 0;
         phase   = 0;
         held    = 0;
         row_num = (row_num + 1) & 'h3FF;
         if (row_num == 0) row_num = 'h3FF;
      end else begin
         row_pos = (row_pos + 1) & 'hFFF;
      end
   endtask

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------

   // Send one beat: idle a random number of cycles, then hold it until taken.
   // Enter and leave on a falling edge.
   task automatic push_beat(input logic kind, input logic [7:0] data, input logic [7:0] index,
                            input logic [7:0] red, input logic [7:0] green,
                            input logic [7:0] blue);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_kind        <= kind;
      req_data_byte   <= data;
      req_entry_index <= index;
      req_entry_red   <= red;
      req_entry_green <= green;
      req_entry_blue  <= blue;
      req_push        <= 1'b1;
      do @(posedge clock); while (req_full);
      decode_beat(kind, data, index, red, green, blue);
      @(negedge clock);
   endtask

   // Palette fields ride along with junk on a data beat, and the reverse.
   task automatic push_data(input logic [7:0] data);
      push_beat(KIND_DATA, data, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   task automatic push_entry(input logic [7:0] index, input logic [7:0] red,
                             input logic [7:0] green, input logic [7:0] blue);
      push_beat(KIND_ENTRY, 8'($urandom), index, red, green, blue);
   endtask

   // Stop sending and let every predicted pixel drain, plus the pipe depth.
   task automatic drain();
      req_push <= 1'b0;
      while (pixels_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Hold csr_write high; the caller lowers it after the last register.
   task automatic write_reg(input bmprt_pkg::reg_index_type idx, input int value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= 10'(value);
      case (idx)
         bmprt_pkg::REG_DEPTH_CODE:  mode_depth   = 3'(value);
         bmprt_pkg::REG_FORMAT_565:  mode_565     = value[0];
         bmprt_pkg::REG_WITH_COLOR:  mode_color   = value[0];
         bmprt_pkg::REG_IMAGE_WIDTH: mode_image_w = value & 'h3FF;
         bmprt_pkg::REG_DRAW_WIDTH:  mode_draw_w  = value & 'h3FF;
         bmprt_pkg::REG_DRAW_HEIGHT: mode_height  = value & 'h3FF;
         bmprt_pkg::REG_ORIGIN_X:    mode_ox      = value & 'h3FF;
         bmprt_pkg::REG_ORIGIN_Y:    mode_oy      = value & 'h3FF;
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Reprogram every register while the decoder is idle.
   task automatic set_mode(input logic [2:0] depth, input logic wide_green, input logic color,
                           input int image_w, input int draw_w, input int height,
                           input int ox, input int oy);
      drain();
      write_reg(bmprt_pkg::REG_DEPTH_CODE, depth);
      write_reg(bmprt_pkg::REG_FORMAT_565, wide_green);
      write_reg(bmprt_pkg::REG_WITH_COLOR, color);
      write_reg(bmprt_pkg::REG_IMAGE_WIDTH, image_w);
      write_reg(bmprt_pkg::REG_DRAW_WIDTH, draw_w);
      write_reg(bmprt_pkg::REG_DRAW_HEIGHT, height);
      write_reg(bmprt_pkg::REG_ORIGIN_X, ox);
      write_reg(bmprt_pkg::REG_ORIGIN_Y, oy);
      csr_write <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Checker
   // ------------------------------------------------------------------

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      // Cap the log; the count still grows.
      if (mismatch_count <= 200) begin
         $display("%0t: %s got %0d want %0d", $time, what, got, want);
      end
   endtask

   task automatic check_pixel();
      drawn_pixel_type due;
      if (pixels_due.size() == 0) begin
         report_mismatch("pixel with none due, x", rsp_pixel_x, -1);
         return;
      end
      due = pixels_due.pop_front();
      if (rsp_pixel_x !== due.x) report_mismatch("pixel_x", rsp_pixel_x, due.x);
      if (rsp_pixel_y !== due.y) report_mismatch("pixel_y", rsp_pixel_y, due.y);
      if (rsp_pixel_color !== due.color) begin
         report_mismatch("pixel_color", rsp_pixel_color, due.color);
      end
      if (rsp_last_of_item !== due.last) begin
         report_mismatch("last_of_item", rsp_last_of_item, due.last);
      end
   endtask

   // Pop side: stall a random number of cycles before each beat, sample on the
   // rising edge, change rsp_pop only on the falling edge.
   initial begin : pixel_sink
      int stall;
      do @(negedge clock); while (reset);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 16);
         if (stall > 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         check_pixel();
         @(negedge clock);
      end
   end

   // Abort when no beat moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no beat moved in %0d cycles", WATCHDOG_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Out of reset the drawn height is zero, so data beats draw nothing.
   task automatic test_rows_exhausted();
      push_data(8'h00);
      push_data(8'hFF);
   endtask

   // Load palette entries under both whitish tests.
   task automatic test_palette_marks();
      // Per-channel test: black, white, and a green-and-blue entry that marks as colored.
      set_mode(bmprt_pkg::DEPTH_8BPP, 1'b0, 1'b1, 1, 0, 0, 0, 0);
      push_entry(8'd0, 8'h00, 8'h00, 8'h00);
      push_entry(8'd1, 8'hFF, 8'hFF, 8'hFF);
      push_entry(8'd128, 8'h00, 8'hF1, 8'hF1);
      // 1 bpp forces the summed test even with color requested: just over the limit.
      set_mode(bmprt_pkg::DEPTH_1BPP, 1'b0, 1'b1, 1, 0, 0, 0, 0);
      push_entry(8'd255, 8'h80, 8'h80, 8'h81);
   endtask

   // One full 1 bpp row: two full bytes, a partial byte, then padding.
   task automatic test_one_bit_row();
      set_mode(bmprt_pkg::DEPTH_1BPP, 1'b0, 1'b1, 20, 20, row_num + 1, 0, 0);
      push_data(8'hFF);
      push_data(8'h00);
      push_data(8'h5A);
      push_data(8'hC3);
   endtask

   // 4 bpp clipped to three columns, starting at the right edge so x wraps.
   task automatic test_four_bit_clip();
      set_mode(bmprt_pkg::DEPTH_4BPP, 1'b0, 1'b1, 5, 3, row_num + 1, 1022, 0);
      push_data(8'h01);
      push_data(8'h10);
      push_data(8'h11);
      push_data(8'h00);
   endtask

   // Draw width far past the stored width; tallest image, bottom origin.
   task automatic test_eight_bit_wide();
      set_mode(bmprt_pkg::DEPTH_8BPP, 1'b0, 1'b1, 2, 1023, 1023, 0, 1023);
      push_data(8'd128);
      push_data(8'd255);
      push_data(8'd1);
      push_data(8'd0);
   endtask

   // One pixel per row in each 16-bit layout, then two padding bytes.
   task automatic test_sixteen_bit();
      set_mode(bmprt_pkg::DEPTH_16BPP, 1'b0, 1'b1, 1, 1, row_num + 1, 1023, 0);
      push_data(8'hFF);
      push_data(8'h7F);
      push_data(8'h00);
      push_data(8'h00);
      set_mode(bmprt_pkg::DEPTH_16BPP, 1'b1, 1'b1, 1, 1, row_num + 1, 1023, 0);
      push_data(8'h1F);
      push_data(8'hF8);
      push_data(8'hFF);
      push_data(8'hFF);
   endtask

   // A depth code past the table decodes as 24 bpp BGR.
   task automatic test_depth_beyond();
      set_mode(DEPTH_BEYOND_MAX, 1'b0, 1'b1, 1, 1, row_num + 1, 0, 0);
      push_data(8'hF1);
      push_data(8'h00);
      push_data(8'hFF);
      push_data(8'h00);
   endtask

   // Zero stored width: every byte closes a row and nothing is drawn.
   task automatic test_zero_row();
      set_mode(bmprt_pkg::DEPTH_24BPP, 1'b0, 1'b0, 0, 5, row_num + 2, 0, 0);
      push_data(8'hFF);
      push_data(8'hFF);
   endtask

   // Palette component biased toward the thresholds.
   function automatic logic [7:0] level();
      case ($urandom_range(0, 5))
         0:       return 8'h80;
         1:       return 8'h81;
         2:       return 8'hF0;
         3:       return 8'hF1;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // At least half the entries land in the low sixteen so 4 bpp gains variety.
   function automatic logic [7:0] entry_pick();
      return $urandom_range(0, 1) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255));
   endfunction

   // Random data byte; its palette pixels use loaded entries where found, else entry zero.
   function automatic logic [7:0] safe_byte();
      int bpp, pick, tries;
      logic [7:0] value;
      bpp = pixel_bits();
      if (bpp >= 16) return 8'($urandom_range(0, 255));
      value = '0;
      for (int s = 0; s < 8 / bpp; s++) begin
         pick = $urandom_range(0, (1 << bpp) - 1);
         for (tries = 0; tries < 8 && !entry_written[pick]; tries++) begin
            pick = $urandom_range(0, (1 << bpp) - 1);
         end
         if (!entry_written[pick]) pick = 0;
         value = 8'((int'(value) << bpp) | pick);
      end
      return value;
   endfunction

   // Random phases: new settings, an optional palette batch, then mostly whole
   // padded rows with random content; some truncated rows and stray entries.
   task automatic test_random_stream();
      int sent, count, remain, row_len, entries;
      int image_w, draw_w, height, ox, oy;
      logic [2:0] depth;
      sent = 0;
      while (sent < RANDOM_BEATS) begin
         depth   = 3'($urandom_range(0, 7));
         image_w = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 1023)
                                                : $urandom_range(1, 16);
         draw_w  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023)
                                               : $urandom_range(0, image_w + 2);
         height  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, row_num)
                                               : row_num + $urandom_range(1, 4);
         if (height > 1023) height = 1023;
         ox = ($urandom_range(0, 3) == 0) ? $urandom_range(1000, 1023)
                                          : $urandom_range(0, 1023);
         oy = $urandom_range(0, 1023);
         set_mode(depth, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  image_w, draw_w, height, ox, oy);
         steady = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 2) == 0) begin
            entries = $urandom_range(1, 6);
            repeat (entries) begin
               push_entry(entry_pick(), level(), level(), level());
               sent++;
            end
         end
         row_len = padded_row_size();
         if (row_len == 0 || row_len > 48) begin
            count = $urandom_range(1, 12);
         end else begin
            // Finish the current row, then add whole rows.
            remain = (row_pos + 1 >= row_len) ? 1 : row_len - row_pos;
            count  = remain + row_len * $urandom_range(0, 2);
            if ($urandom_range(0, 5) == 0) count = $urandom_range(1, 7);
         end
         repeat (count) begin
            if (sent >= RANDOM_BEATS) break;
            if ($urandom_range(0, 15) == 0) begin
               push_entry(entry_pick(), level(), level(), level());
               sent++;
            end
            sent++;
            push_data(safe_byte());
         end
         steady = 1'b0;
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_rows_exhausted();
      test_palette_marks();
      test_one_bit_row();
      test_four_bit_clip();
      test_eight_bit_wide();
      test_sixteen_bit();
      test_depth_beyond();
      test_zero_row();
      test_random_stream();

      drain();
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl
rtl/bmprt_pkg.sv
rtl/bmprt_fifo.sv
rtl/bmprt_front.sv
rtl/bmprt_back.sv
rtl/bmp_row_to_tricolor_pixels.sv
rtl/bmprt_checker.sv
sim/bmp_row_to_tricolor_pixels_test.sv
